// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the encoder modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define AFE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define AFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/afe_pkg.sv =====
// Types, constants and helper functions for the escaped frame encoder.
// No dependencies; used by every encoder module.
package afe_pkg;

  // Wire bytes with a special meaning.
  localparam logic [7:0] DelimByte = 8'h7E;
  localparam logic [7:0] EscByte   = 8'h7D;
  localparam logic [7:0] XonByte   = 8'h11;
  localparam logic [7:0] XoffByte  = 8'h13;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [7:0] CsumBase  = 8'hFF;

  // Queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // One classified request, ready to be serialized.
  typedef struct packed {
    logic        sof;
    logic        has;
    logic        eof;
    logic [15:0] len;
    logic [7:0]  ftype;
    logic [7:0]  dbyte;
    logic [7:0]  csum;
  } afe_entry_t;

  // Head of the queue as seen by the back.
  typedef struct packed {
    logic       valid;
    afe_entry_t entry;
  } afe_head_t;

  // Part of the frame that the back is sending.
  typedef enum logic [5:0] {
    SEG_DELIM  = 6'b000001,
    SEG_LEN_HI = 6'b000010,
    SEG_LEN_LO = 6'b000100,
    SEG_TYPE   = 6'b001000,
    SEG_DATA   = 6'b010000,
    SEG_CSUM   = 6'b100000
  } afe_seg_t;

  // True for bytes that must be sent as an escape pair.
  function automatic logic needs_escape(input logic [7:0] b);
    needs_escape = b inside {DelimByte, EscByte, XonByte, XoffByte};
  endfunction

endpackage

// ===== rtl/core/afe_front.sv =====
// Front of the encoder: accepts requests, keeps the frame state and checksum.
// Depends on afe_pkg.
module afe_front import afe_pkg::*; #(
  parameter int MAX_DATA = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       start_of_frame,
  input  logic       end_of_frame,
  input  logic       has_data,
  input  logic [7:0] frame_type,
  input  logic [8:0] data_count,
  input  logic [7:0] data_byte,
  output logic       push,
  output afe_entry_t push_entry
);

  localparam logic [16:0] MaxData = 17'(MAX_DATA);

  logic       in_frame;
  logic [7:0] running_sum;
  logic [7:0] sum_new;
  logic [15:0] count_sat;
  logic       active;

  // Sum of the type and payload bytes including this request; count clamped to MAX_DATA.
  always_comb begin
    sum_new = (start_of_frame ? frame_type : running_sum) +
              (has_data ? data_byte : 8'h00);
    if (17'(data_count) > MaxData) begin
      count_sat = MaxData[15:0];
    end else begin
      count_sat = 16'(data_count);
    end
    active = start_of_frame || in_frame;
  end

  // A request is queued only if it produces wire bytes.
  assign push = accept && (start_of_frame || (in_frame && (has_data || end_of_frame)));

  always_comb begin
    push_entry.sof   = start_of_frame;
    push_entry.has   = has_data;
    push_entry.eof   = end_of_frame;
    push_entry.len   = count_sat + 16'd1;
    push_entry.ftype = frame_type;
    push_entry.dbyte = data_byte;
    push_entry.csum  = CsumBase - sum_new;
  end

  // Frame state; requests outside a frame that do not open one leave it untouched.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      running_sum <= 8'h00;
    end else if (accept && active) begin
      in_frame    <= !end_of_frame;
      running_sum <= end_of_frame ? 8'h00 : sum_new;
    end
  end

endmodule

// ===== rtl/core/afe_queue.sv =====
// Short queue of classified requests between the front and the back.
// Depends on afe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module afe_queue import afe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  afe_entry_t push_entry,
  input  logic       pop,
  output logic       full,
  output afe_head_t  head
);

  afe_entry_t           mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueueCntW-1:0] cnt;

  assign full       = (cnt == QueueCntW'(QueueDepth));
  assign head.valid = (cnt != '0);
  assign head.entry = mem[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + QueueCntW'(push) - QueueCntW'(pop);
    end
  end

  `AFE_ASSERT_SAME(a_no_overflow, clk, rst, full, !push, "push into a full queue")
  `AFE_ASSERT_SAME(a_no_underflow, clk, rst, !head.valid, !pop, "pop from an empty queue")

endmodule

// ===== rtl/core/afe_back.sv =====
// Back of the encoder: walks the parts of each request and byte-stuffs them.
// Depends on afe_pkg and assert_macros.svh.
`include "assert_macros.svh"
module afe_back import afe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  afe_head_t  head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       frame_end
);

  afe_seg_t   seg;
  logic       busy;
  logic       esc;
  afe_seg_t   cur_seg;
  afe_seg_t   nxt_seg;
  logic       nxt_none;
  logic [7:0] cur_byte;
  logic       emit;
  logic       esc_first;
  logic [7:0] wire_byte;
  logic       last;

  // First part of a fresh request, or the part in progress.
  always_comb begin
    if (busy) begin
      cur_seg = seg;
    end else if (head.entry.sof) begin
      cur_seg = SEG_DELIM;
    end else if (head.entry.has) begin
      cur_seg = SEG_DATA;
    end else begin
      cur_seg = SEG_CSUM;
    end
  end

  // Raw byte of the current part and the part that follows it.
  always_comb begin
    cur_byte = DelimByte;
    nxt_seg  = SEG_CSUM;
    nxt_none = 1'b0;
    case (cur_seg)
      SEG_DELIM: begin
        cur_byte = DelimByte;
        nxt_seg  = SEG_LEN_HI;
      end
      SEG_LEN_HI: begin
        cur_byte = head.entry.len[15:8];
        nxt_seg  = SEG_LEN_LO;
      end
      SEG_LEN_LO: begin
        cur_byte = head.entry.len[7:0];
        nxt_seg  = SEG_TYPE;
      end
      SEG_TYPE: begin
        cur_byte = head.entry.ftype;
        if (head.entry.has) begin
          nxt_seg = SEG_DATA;
        end else begin
          nxt_seg  = SEG_CSUM;
          nxt_none = !head.entry.eof;
        end
      end
      SEG_DATA: begin
        cur_byte = head.entry.dbyte;
        nxt_seg  = SEG_CSUM;
        nxt_none = !head.entry.eof;
      end
      SEG_CSUM: begin
        cur_byte = head.entry.csum;
        nxt_none = 1'b1;
      end
      default: begin
        cur_byte = DelimByte;
        nxt_none = 1'b1;
      end
    endcase
  end

  // One wire byte per cycle whenever a request is queued and the output register is free.
  always_comb begin
    emit      = head.valid && (!out_valid || out_ready);
    esc_first = !esc && (cur_seg != SEG_DELIM) && needs_escape(cur_byte);
    if (esc_first) begin
      wire_byte = EscByte;
    end else if (esc) begin
      wire_byte = cur_byte ^ EscXor;
    end else begin
      wire_byte = cur_byte;
    end
    last = !esc_first && nxt_none;
    pop  = emit && last;
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      esc  <= 1'b0;
      seg  <= SEG_DELIM;
    end else if (emit) begin
      esc  <= esc_first;
      busy <= !last;
      seg  <= esc_first ? cur_seg : nxt_seg;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= wire_byte;
      run_end   <= last;
      frame_end <= last && (cur_seg == SEG_CSUM);
    end
  end

  `AFE_ASSERT_SAME(a_esc_in_request, clk, rst, esc, busy, "escape pending outside a request")
  `AFE_ASSERT_NEXT(a_esc_pair, clk, rst, emit && esc_first, esc && out_byte == EscByte, "escape pair broken")

endmodule

// ===== rtl/core/api_frame_escape_encoder_top.sv =====
// Channel   Signals                                         Direction
// input     in_valid, in_ready, start_of_frame .. data_byte into block
// output    out_valid, out_ready, out_byte, run_end, frame_end  out of block
//
// The back emits one wire byte per cycle unless the output stalls; a request
// yields 1 to 10 wire bytes, a lone payload byte one, or two when escaped.
// A four-entry queue lets the front accept a request every cycle while the
// back works; in_ready drops only when that queue is full.
// Reset is synchronous and active high; it empties the queue and closes any
// open frame. A stalled output holds its byte while new requests still enter.
// Top level of the escaped frame encoder; depends on afe_pkg, afe_front,
// afe_queue and afe_back.
module api_frame_escape_encoder_top import afe_pkg::*; #(
  parameter int MAX_DATA = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       start_of_frame,
  input  logic       end_of_frame,
  input  logic       has_data,
  input  logic [7:0] frame_type,
  input  logic [8:0] data_count,
  input  logic [7:0] data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       frame_end
);

  logic       accept;
  logic       push;
  afe_entry_t push_entry;
  logic       pop;
  logic       full;
  afe_head_t  head;

  // Requests are taken whenever the queue has room.
  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  afe_front #(
    .MAX_DATA(MAX_DATA)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .start_of_frame(start_of_frame),
    .end_of_frame  (end_of_frame),
    .has_data      (has_data),
    .frame_type    (frame_type),
    .data_count    (data_count),
    .data_byte     (data_byte),
    .push          (push),
    .push_entry    (push_entry)
  );

  afe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (full),
    .head      (head)
  );

  afe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .run_end  (run_end),
    .frame_end(frame_end)
  );

endmodule

// ===== tb/api_frame_escape_encoder_top_test.sv =====
// Testbench for the escaped frame encoder: directed and random frames, with the
// expected wire bytes checked against every output handshake.
// Depends on afe_pkg and api_frame_escape_encoder_top.
`timescale 1ns / 100ps

module api_frame_escape_encoder_top_test;
  import afe_pkg::*;

  localparam int MAX_DATA = 256;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 20;
  localparam int PHASE_REQUESTS = 50;

  // One expected byte on the wire.
  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       frame_end;
  } wire_byte_t;

  // Tracks the open frame and the wire bytes that accepted requests must produce.
  class wire_byte_tracker;
    wire_byte_t  pending[$];
    logic [7:0]  frame_sum;
    bit          frame_open;
    int unsigned mismatch_count;

    function new();
      frame_sum = 8'h00;
      frame_open = 1'b0;
      mismatch_count = 0;
    endfunction

    function void push_raw(logic [7:0] b);
      wire_byte_t w;
      w.data = b;
      w.run_end = 1'b0;
      w.frame_end = 1'b0;
      pending.push_back(w);
    endfunction

    // Bytes that clash with framing or flow control go out as an escape pair.
    function void push_stuffed(logic [7:0] b);
      if (b inside {DelimByte, EscByte, XonByte, XoffByte}) begin
        push_raw(EscByte);
        push_raw(b ^ EscXor);
      end else begin
        push_raw(b);
      end
    endfunction

    // Works out the wire bytes of one accepted request.
    function void note_request(logic sof, logic eof, logic has, logic [7:0] ftype,
                               logic [8:0] count, logic [7:0] dbyte);
      int unsigned first;
      logic [15:0] len;
      first = pending.size();
      // A request outside a frame that does not open one is dropped.
      if (!sof && !frame_open) return;
      if (sof) begin
        len = ((count > MAX_DATA) ? 16'(MAX_DATA) : 16'(count)) + 16'd1;
        push_raw(DelimByte);
        push_stuffed(len[15:8]);
        push_stuffed(len[7:0]);
        push_stuffed(ftype);
        frame_sum = ftype;
        frame_open = 1'b1;
      end
      if (has) begin
        push_stuffed(dbyte);
        frame_sum = frame_sum + dbyte;
      end
      if (eof) begin
        push_stuffed(CsumBase - frame_sum);
        pending[pending.size() - 1].frame_end = 1'b1;
        frame_open = 1'b0;
        frame_sum = 8'h00;
      end
      if (pending.size() > first) pending[pending.size() - 1].run_end = 1'b1;
    endfunction

    // Compares one output handshake with the oldest expected byte.
    function void check_wire_byte(logic [7:0] b, logic re, logic fe);
      wire_byte_t w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected byte %h run_end %b frame_end %b", $time, b, re, fe);
        mismatch_count++;
        return;
      end
      w = pending.pop_front();
      if (b !== w.data || re !== w.run_end || fe !== w.frame_end) begin
        $display("%0t: expected byte %h run_end %b frame_end %b, actual %h %b %b",
                 $time, w.data, w.run_end, w.frame_end, b, re, fe);
        mismatch_count++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       start_of_frame = 1'b0;
  logic       end_of_frame = 1'b0;
  logic       has_data = 1'b0;
  logic [7:0] frame_type = 8'h00;
  logic [8:0] data_count = 9'h000;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;
  logic       frame_end;

  wire_byte_tracker board = new();
  int unsigned send_idle_pct = 28;
  int unsigned recv_idle_pct = 51;
  int unsigned stall_cycles = 0;
  int unsigned frame_requests = 0;
  bit          handshake_seen;

  api_frame_escape_encoder_top #(.MAX_DATA(MAX_DATA)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .start_of_frame(start_of_frame), .end_of_frame(end_of_frame),
    .has_data(has_data), .frame_type(frame_type),
    .data_count(data_count), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .run_end(run_end), .frame_end(frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The receiver stalls at random at the current rate.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Note accepted requests, check accepted bytes, and count quiet cycles.
  always @(posedge clk) begin
    if (!rst) begin
      handshake_seen = 1'b0;
      if (in_valid && in_ready) begin
        board.note_request(start_of_frame, end_of_frame, has_data, frame_type,
                           data_count, data_byte);
        handshake_seen = 1'b1;
      end
      if (out_valid && out_ready) begin
        board.check_wire_byte(out_byte, run_end, frame_end);
        handshake_seen = 1'b1;
      end
      stall_cycles = handshake_seen ? 0 : stall_cycles + 1;
    end
  end

  // Ends the run when nothing has moved for too long.
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Biased toward bytes that need escaping.
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(9) >= 3) return 8'($urandom_range(255));
    case ($urandom_range(3))
      0: return DelimByte;
      1: return EscByte;
      2: return XonByte;
      default: return XoffByte;
    endcase
  endfunction

  // Presents one request after a random gap and holds it until accepted.
  task automatic push_request(input logic sof, input logic eof, input logic has,
                              input logic [7:0] ftype, input logic [8:0] count,
                              input logic [7:0] dbyte);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    start_of_frame <= sof;
    end_of_frame <= eof;
    has_data <= has;
    frame_type <= ftype;
    data_count <= count;
    data_byte <= dbyte;
    do @(posedge clk); while (!in_ready);
  endtask

  // One mostly well-formed frame; some are cut short or carry empty requests.
  task automatic send_random_frame();
    int unsigned n_data;
    logic [8:0] count;
    count = ($urandom_range(9) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(8));
    n_data = (count <= 8 && $urandom_range(3) != 0) ? count : $urandom_range(6);
    if ($urandom_range(5) == 0) begin
      push_request(1'b1, 1'b1, 1'($urandom_range(1)), pick_byte(), count, pick_byte());
      frame_requests++;
      return;
    end
    push_request(1'b1, 1'b0, 1'($urandom_range(1)), pick_byte(), count, pick_byte());
    frame_requests++;
    for (int unsigned i = 0; i < n_data; i++) begin
      push_request(1'b0, 1'b0, 1'($urandom_range(7) != 0), 8'($urandom_range(255)),
                   9'($urandom_range(511)), pick_byte());
      frame_requests++;
    end
    // Now and then the frame is left open for the next start to abandon.
    if ($urandom_range(9) == 0) return;
    push_request(1'b0, 1'b1, 1'($urandom_range(1)), 8'($urandom_range(255)),
                 9'($urandom_range(511)), pick_byte());
    frame_requests++;
  endtask

  task automatic wait_drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Stray request while idle, then an empty frame.
    push_request(1'b0, 1'b1, 1'b1, 8'h5A, 9'h1FF, 8'hA5);
    push_request(1'b1, 1'b1, 1'b0, 8'h00, 9'h000, 8'h00);
    // Everything in one request, with the low length, type and data escaped.
    push_request(1'b1, 1'b1, 1'b1, DelimByte, 9'h07C, EscByte);
    // Multi-request frame with an empty request in the middle.
    push_request(1'b1, 1'b0, 1'b0, XonByte, 9'h010, 8'h00);
    push_request(1'b0, 1'b0, 1'b1, 8'h00, 9'h000, XoffByte);
    push_request(1'b0, 1'b0, 1'b0, 8'hFF, 9'h1FF, 8'hFF);
    push_request(1'b0, 1'b0, 1'b1, 8'h00, 9'h000, 8'hFF);
    push_request(1'b0, 1'b1, 1'b0, 8'h00, 9'h000, 8'h00);
    // Oversized count, then a restart inside the open frame; checksum is escaped.
    push_request(1'b1, 1'b0, 1'b1, 8'hFF, 9'h1FF, XonByte);
    push_request(1'b1, 1'b0, 1'b1, XoffByte, 9'h012, DelimByte);
    push_request(1'b0, 1'b1, 1'b1, 8'h00, 9'h000, 8'hF0);
    // Full count, length low byte equal to the delimiter, other escaped checksums.
    push_request(1'b1, 1'b1, 1'b0, EscByte, 9'h100, 8'h00);
    push_request(1'b1, 1'b1, 1'b0, 8'h82, 9'h07D, 8'h00);
    push_request(1'b1, 1'b1, 1'b0, 8'hEE, 9'h0AA, 8'h00);
    push_request(1'b1, 1'b1, 1'b0, 8'hEC, 9'h155, 8'h00);
    push_request(1'b1, 1'b0, 1'b1, 8'hAA, 9'h0FF, 8'h00);
    push_request(1'b0, 1'b1, 1'b1, 8'h55, 9'h001, 8'h54);
    // Ignored request after the frame closed.
    push_request(1'b0, 1'b0, 1'b0, 8'h00, 9'h000, 8'h00);

    // Random frames under three idling patterns.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 51 : 0;
      recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 28 : 0;
      while (frame_requests < PHASE_REQUESTS * (phase + 1)) begin
        if ($urandom_range(9) == 0) begin
          push_request(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                       8'($urandom_range(255)), 9'($urandom_range(511)), pick_byte());
        end else begin
          send_random_frame();
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drain();

    if (board.mismatch_count == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== api_frame_escape_encoder_top.f =====
+incdir+rtl/core
rtl/core/afe_pkg.sv
rtl/core/afe_front.sv
rtl/core/afe_queue.sv
rtl/core/afe_back.sv
rtl/core/api_frame_escape_encoder_top.sv
tb/api_frame_escape_encoder_top_test.sv
